>>> sv/scc_pkg.sv
// Shared types, constants and helpers for the spike cross-correlogram unit.
// No dependencies; imported by spike_cross_correlogram_unit.
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

   localparam int MAX_MARKS     = 8;
   localparam int MARK_BITS     = 3;
   localparam int MAX_HALF_BINS = 31;
   localparam int NUM_BINS      = 2 * MAX_HALF_BINS + 1;
   localparam int STORE_DEPTH   = MAX_MARKS * MAX_MARKS * NUM_BINS;
   localparam int STORE_AW      = $clog2(STORE_DEPTH);
   localparam int TIME_BITS     = 32;
   localparam int BS_BITS       = 16;
   localparam int HB_BITS       = 5;
   localparam int NM_BITS       = 4;
   localparam int BIN_BITS      = 6;
   localparam int LIM_BITS      = BS_BITS + HB_BITS + 1;
   localparam int REM_BITS      = LIM_BITS + 1;
   localparam int QUO_BITS      = 6;
   localparam int PAIR_BITS     = 8;
   localparam int STATUS_BITS   = 2;
   localparam int CSR_AW        = 4;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK       = 2'd0,
      STAT_BAD_MARK = 2'd1,
      STAT_ORDER    = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_BIN_SIZE  = 2'd0,
      REG_HALF_BINS = 2'd1,
      REG_NUM_MARKS = 2'd2
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_OVF_RD, ST_OVF_CHK, ST_WALK_RD, ST_WALK_CHK, ST_DIV,
      ST_B1_RD, ST_B1_WR, ST_B2_RD, ST_B2_WR, ST_PUSH, ST_CNT_RD, ST_CNT_WAIT, ST_DONE
   } state_type;

   // Flat count index: (first * MAX_MARKS + second) * NUM_BINS + bin
   function automatic logic [STORE_AW-1:0] count_addr(input logic [MARK_BITS-1:0] m1,
                                                     input logic [MARK_BITS-1:0] m2,
                                                     input logic [BIN_BITS-1:0] bin);
      logic [STORE_AW-1:0] pair;
      pair = STORE_AW'(m1) * STORE_AW'(MAX_MARKS) + STORE_AW'(m2);
      return pair * STORE_AW'(NUM_BINS) + STORE_AW'(bin);
   endfunction

endpackage
`default_nettype wire

>>> sv/scc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> sv/spike_cross_correlogram_unit.sv
// Spike cross-correlogram unit: window RAM, count RAM and the walk sequencer.
// Depends on scc_pkg and scc_ram.
//
// Usage:
//   req_* words carry either a spike (kind 0: time, mark) or a count read
//   (kind 1: first mark, second mark, bin). Every word yields exactly one rsp_*
//   word with status, pairs_added and count_value.
//   csr_* is an APB-style port holding bin_size (0x0), half_bins (0x4) and
//   num_marks (0x8); write it only while the unit is idle.
// Sequence (one word at a time, from accept to rsp_valid):
//   rejected word (bad mark, time out of order): straight to the done state.
//   count read: one count RAM read, then the done state.
//   spike: when the window is full, the oldest entry is read and checked
//   first; the walk then reads entries newest first until one is out of
//   reach or the window ends, then pushes the spike; each entry in reach
//   goes through the bit-serial bin divider and a count RAM read-modify-write
//   for each of its one or two bumped bins. The next word is accepted once
//   the finished result has moved into the rsp register.
// Reset: all configuration returns to defaults, the window empties and the
//   count RAM is swept to zero, one entry per cycle over all STORE_DEPTH (4032)
//   entries, during which req_ready stays low.
// Stall: the finished word waits in the rsp register; the next request is
//   accepted meanwhile, and its result holds in the sequencer until rsp frees.
`timescale 1ns / 1ps
`default_nettype none
module spike_cross_correlogram_unit #(
   parameter int WINDOW_DEPTH = 64,
   parameter int COUNT_BITS   = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic [scc_pkg::TIME_BITS-1:0]     req_spike_time,
   input  wire logic [3:0]                        req_spike_mark,
   input  wire logic [3:0]                        req_read_first_mark,
   input  wire logic [3:0]                        req_read_second_mark,
   input  wire logic [scc_pkg::BIN_BITS-1:0]      req_read_bin,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [scc_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [scc_pkg::PAIR_BITS-1:0]          rsp_pairs_added,
   output logic [COUNT_BITS-1:0]                  rsp_count_value,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [scc_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   import scc_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int FW = $clog2(WINDOW_DEPTH + 1);
   localparam int WW = TIME_BITS + MARK_BITS;
   localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW_DEPTH - 1);
   localparam logic [FW-1:0] FULL     = FW'(WINDOW_DEPTH);

   // ---------------- configuration registers ----------------
   logic [BS_BITS-1:0] bin_size_ff;
   logic [HB_BITS-1:0] half_bins_ff;
   logic [NM_BITS-1:0] num_marks_ff;
   logic               csr_wr;
   csr_reg_type        csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff  <= BS_BITS'(1);
         half_bins_ff <= HB_BITS'(10);
         num_marks_ff <= NM_BITS'(8);
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_BIN_SIZE:  bin_size_ff  <= csr_pwdata[BS_BITS-1:0];
            REG_HALF_BINS: half_bins_ff <= csr_pwdata[HB_BITS-1:0];
            REG_NUM_MARKS: num_marks_ff <= csr_pwdata[NM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_BIN_SIZE:  csr_prdata = 32'(bin_size_ff);
         REG_HALF_BINS: csr_prdata = 32'(half_bins_ff);
         REG_NUM_MARKS: csr_prdata = 32'(num_marks_ff);
         default:       csr_prdata = 32'd0;
      endcase
   end

   // Effective settings: zero bin acts as one, clamp the others.
   logic [BS_BITS-1:0]  bs_eff;
   logic [HB_BITS-1:0]  h_eff;
   logic [NM_BITS-1:0]  nm_eff;
   logic [LIM_BITS-1:0] limit_ff;

   assign bs_eff = (bin_size_ff == '0) ? BS_BITS'(1) : bin_size_ff;
   assign h_eff  = (32'(half_bins_ff) > MAX_HALF_BINS) ? HB_BITS'(MAX_HALF_BINS) : half_bins_ff;
   assign nm_eff = (32'(num_marks_ff) > MAX_MARKS) ? NM_BITS'(MAX_MARKS) : num_marks_ff;

   // Reach limit bin_size*(2*half_bins+1), registered from the effective settings.
   always_ff @(posedge clock) begin
      limit_ff <= LIM_BITS'(bs_eff) * LIM_BITS'({h_eff, 1'b1});
   end

   // ---------------- sequencer state ----------------
   state_type              state_ff, state_in;
   logic [STORE_AW-1:0]    clr_ff, clr_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic [TIME_BITS-1:0]   last_ff, last_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [FW-1:0]          kcnt_ff, kcnt_in;
   logic [TIME_BITS-1:0]   t_ff, t_in;
   logic [MARK_BITS-1:0]   m1_ff, m1_in;
   logic [MARK_BITS-1:0]   m2_ff, m2_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [QUO_BITS-1:0]    quo_ff, quo_in;
   logic [2:0]             dcnt_ff, dcnt_in;
   logic                   strict_ff, strict_in;
   logic [STORE_AW-1:0]    caddr_ff, caddr_in;
   logic [STATUS_BITS-1:0] stat_ff, stat_in;
   logic [PAIR_BITS-1:0]   pairs_ff, pairs_in;
   logic [COUNT_BITS-1:0]  cval_ff, cval_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [PAIR_BITS-1:0]   rsp_pairs_ff, rsp_pairs_in;
   logic [COUNT_BITS-1:0]  rsp_cval_ff, rsp_cval_in;

   // memory ports
   logic                  win_we, win_re;
   logic [AW-1:0]         win_raddr;
   logic [WW-1:0]         win_rdata;
   logic                  cnt_we, cnt_re;
   logic [STORE_AW-1:0]   cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

   // datapath helpers
   logic                    accept;
   logic                    out_free;
   logic [TIME_BITS:0]      dist2;
   logic [LIM_BITS:0]       lim_x;
   logic [REM_BITS-1:0]     trial;
   logic [QUO_BITS-1:0]     q_low;
   logic [BIN_BITS-1:0]     bin_b1, bin_b2;
   logic [STORE_AW-1:0]     addr_b1, addr_b2;
   logic [COUNT_BITS-1:0]   cnt_inc;
   logic                    rd_marks_bad, rd_bin_ok, sp_mark_bad;
   logic [AW-1:0]           head_prev;

   assign accept   = req_valid & req_ready;
   assign out_free = !rsp_valid_ff | rsp_ready;
   assign dist2    = {t_ff - win_rdata[WW-1:MARK_BITS], 1'b0};
   assign lim_x    = {1'b0, limit_ff};
   assign trial    = REM_BITS'({bs_eff, 1'b0}) << dcnt_ff;
   // floor((a+bs-1)/2bs) is one less than floor((a+bs)/2bs) on an exact hit
   assign q_low    = (rem_ff == '0) ? quo_ff - QUO_BITS'(1) : quo_ff;
   assign bin_b1   = BIN_BITS'(h_eff) - BIN_BITS'(q_low);
   assign bin_b2   = BIN_BITS'(h_eff) + BIN_BITS'(quo_ff);
   assign addr_b1  = count_addr(m1_ff, m2_ff, bin_b1);
   assign addr_b2  = count_addr(m2_ff, m1_ff, bin_b2);
   assign cnt_inc  = (&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
   assign head_prev = (head_ff == '0) ? LAST_PTR : head_ff - AW'(1);

   assign rd_marks_bad = (req_read_first_mark == '0) || (req_read_first_mark > nm_eff) ||
                         (req_read_second_mark == '0) || (req_read_second_mark > nm_eff);
   assign rd_bin_ok    = 7'(req_read_bin) <= 7'({h_eff, 1'b0});
   assign sp_mark_bad  = (req_spike_mark == '0) || (req_spike_mark > nm_eff);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (32'(clr_ff) == STORE_DEPTH - 1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_kind) begin
                  state_in = (!rd_marks_bad && rd_bin_ok) ? ST_CNT_RD : ST_DONE;
               end else if (sp_mark_bad || req_spike_time < last_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = (fill_ff == FULL) ? ST_OVF_RD : ST_WALK_RD;
               end
            end
         end
         ST_OVF_RD:   state_in = ST_OVF_CHK;
         ST_OVF_CHK:  state_in = ST_WALK_RD;
         ST_WALK_RD:  state_in = (kcnt_ff == fill_ff) ? ST_PUSH : ST_WALK_CHK;
         ST_WALK_CHK: state_in = (dist2 > (TIME_BITS+1)'(lim_x)) ? ST_PUSH : ST_DIV;
         ST_DIV:      if (dcnt_ff == '0) state_in = ST_B1_RD;
         ST_B1_RD:    state_in = ST_B1_WR;
         ST_B1_WR:    state_in = strict_ff ? ST_B2_RD : ST_WALK_RD;
         ST_B2_RD:    state_in = ST_B2_WR;
         ST_B2_WR:    state_in = ST_WALK_RD;
         ST_PUSH:     state_in = ST_DONE;
         ST_CNT_RD:   state_in = ST_CNT_WAIT;
         ST_CNT_WAIT: state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // ---------------- memory controls ----------------
   // Each bump reads, then writes, before the next read is issued, so two
   // bumps to the same count never overlap.
   always_comb begin
      req_ready = 1'b0;
      win_we    = 1'b0;
      win_re    = 1'b0;
      win_raddr = ptr_ff;
      cnt_we    = 1'b0;
      cnt_re    = 1'b0;
      cnt_raddr = caddr_ff;
      cnt_waddr = caddr_ff;
      cnt_wdata = cnt_inc;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
         end
         ST_IDLE:    req_ready = 1'b1;
         ST_OVF_RD: begin
            win_re    = 1'b1;
            win_raddr = head_ff;
         end
         ST_WALK_RD: win_re = (kcnt_ff != fill_ff);
         ST_B1_RD: begin
            cnt_re    = 1'b1;
            cnt_raddr = addr_b1;
         end
         ST_B2_RD: begin
            cnt_re    = 1'b1;
            cnt_raddr = addr_b2;
         end
         ST_B1_WR, ST_B2_WR: cnt_we = 1'b1;
         ST_PUSH:    win_we = 1'b1;
         ST_CNT_RD:  cnt_re = 1'b1;
         default: ;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      clr_in        = clr_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      last_in       = last_ff;
      ptr_in        = ptr_ff;
      kcnt_in       = kcnt_ff;
      t_in          = t_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      strict_in     = strict_ff;
      caddr_in      = caddr_ff;
      stat_in       = stat_ff;
      pairs_in      = pairs_ff;
      cval_in       = cval_ff;
      rsp_valid_in  = rsp_valid_ff & !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pairs_in  = rsp_pairs_ff;
      rsp_cval_in   = rsp_cval_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + STORE_AW'(1);
         ST_IDLE: begin
            if (accept) begin
               t_in     = req_spike_time;
               m1_in    = MARK_BITS'(req_spike_mark - NM_BITS'(1));
               pairs_in = '0;
               cval_in  = '0;
               kcnt_in  = '0;
               ptr_in   = head_prev;
               stat_in  = STAT_OK;
               caddr_in = count_addr(MARK_BITS'(req_read_first_mark - NM_BITS'(1)),
                                     MARK_BITS'(req_read_second_mark - NM_BITS'(1)),
                                     req_read_bin);
               if (req_kind) begin
                  if (rd_marks_bad) stat_in = STAT_BAD_MARK;
               end else if (sp_mark_bad) begin
                  stat_in = STAT_BAD_MARK;
               end else if (req_spike_time < last_ff) begin
                  stat_in = STAT_ORDER;
               end
            end
         end
         ST_OVF_CHK: begin
            // drop the oldest; flag it if it was still within reach
            if (dist2 <= (TIME_BITS+1)'(lim_x)) stat_in = STAT_OVERFLOW;
            fill_in = FULL - FW'(1);
         end
         ST_WALK_CHK: begin
            m2_in     = win_rdata[MARK_BITS-1:0];
            rem_in    = REM_BITS'(dist2) + REM_BITS'(bs_eff);
            quo_in    = '0;
            dcnt_in   = 3'(QUO_BITS - 1);
            strict_in = dist2 < (TIME_BITS+1)'(lim_x);
         end
         ST_DIV: begin
            // one quotient bit per cycle, restoring
            if (rem_ff >= trial) begin
               rem_in          = rem_ff - trial;
               quo_in[dcnt_ff] = 1'b1;
            end
            dcnt_in = dcnt_ff - 3'd1;
         end
         ST_B1_RD: caddr_in = addr_b1;
         ST_B2_RD: caddr_in = addr_b2;
         ST_B1_WR, ST_B2_WR: begin
            if (pairs_ff != '1) pairs_in = pairs_ff + PAIR_BITS'(1);
            if (state_ff == ST_B2_WR || !strict_ff) begin
               kcnt_in = kcnt_ff + FW'(1);
               ptr_in  = (ptr_ff == '0) ? LAST_PTR : ptr_ff - AW'(1);
            end
         end
         ST_PUSH: begin
            head_in = (head_ff == LAST_PTR) ? '0 : head_ff + AW'(1);
            fill_in = fill_ff + FW'(1);
            last_in = t_ff;
         end
         ST_CNT_WAIT: cval_in = cnt_rdata;
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_pairs_in  = pairs_ff;
               rsp_cval_in   = cval_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      kcnt_ff       <= kcnt_in;
      t_ff          <= t_in;
      m1_ff         <= m1_in;
      m2_ff         <= m2_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dcnt_ff       <= dcnt_in;
      strict_ff     <= strict_in;
      caddr_ff      <= caddr_in;
      stat_ff       <= stat_in;
      pairs_ff      <= pairs_in;
      cval_ff       <= cval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pairs_ff  <= rsp_pairs_in;
      rsp_cval_ff   <= rsp_cval_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pairs_added = rsp_pairs_ff;
   assign rsp_count_value = rsp_cval_ff;

   // ---------------- memories ----------------
   scc_ram #(.WIDTH(WW), .DEPTH(WINDOW_DEPTH)) u_window (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (head_ff),
      .wr_data ({t_ff, m1_ff}),
      .rd_en   (win_re),
      .rd_addr (win_raddr),
      .rd_data (win_rdata)
   );

   scc_ram #(.WIDTH(COUNT_BITS), .DEPTH(STORE_DEPTH)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   // ---------------- assertions ----------------
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request accepted during count clearing");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("window fill beyond depth");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second request taken while one is in progress");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_CHK) |-> (kcnt_ff < fill_ff))
      else $error("walk past the window fill");

endmodule
`default_nettype wire

>>> tb/spike_cross_correlogram_unit_tb.sv
// Self-checking testbench for spike_cross_correlogram_unit: directed table, then random spikes
// and count reads over several register settings, checked against the table or a predictor.
// Depends on scc_pkg and the unit's RTL only.
`timescale 1ns / 1ps
module spike_cross_correlogram_unit_tb;
   import scc_pkg::*;

   localparam int WIN_DEPTH   = 64;
   localparam int WATCH_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_kind = 0;
   logic [31:0] req_spike_time = 0;
   logic [3:0]  req_spike_mark = 0;
   logic [3:0]  req_read_first_mark = 0;
   logic [3:0]  req_read_second_mark = 0;
   logic [5:0]  req_read_bin = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_pairs_added;
   logic [31:0] rsp_count_value;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   spike_cross_correlogram_unit dut (.*);

   always #4 clock = ~clock;

   typedef struct packed {
      status_type  status;
      logic [7:0]  pairs;
      logic [31:0] count;
   } result_type;

   typedef struct {
      logic        kind;
      logic [31:0] t;
      logic [3:0]  mark;
      logic [3:0]  r1;
      logic [3:0]  r2;
      logic [5:0]  rb;
      logic        fixed;
      result_type  want;
   } stim_row_type;

   // Predictor copy of the unit's registers and state
   logic [15:0] cfg_bin_size;
   logic [4:0]  cfg_half_bins;
   logic [3:0]  cfg_num_marks;
   logic [31:0] win_time [WIN_DEPTH];
   logic [2:0]  win_mark [WIN_DEPTH];
   int          win_head, win_fill;
   logic [31:0] last_spike_time;
   logic [31:0] hist_count [STORE_DEPTH];

   result_type  pending_results[$];
   int          mismatches = 0;
   int          spikes_seen = 0, reads_seen = 0, overflow_seen = 0, results_seen = 0;
   int          stall_cycles = 0;
   bit          idling_on = 1;
   bit          hold_req = 0;
   // Word currently offered by the sender, seen by the monitor at accept
   bit          cur_fixed = 0;
   result_type  cur_want;
   logic [31:0] cur_time;

   function automatic longint unsigned eff_bin();
      return (cfg_bin_size == 0) ? 1 : longint'(cfg_bin_size);
   endfunction

   function automatic int eff_marks();
      return (cfg_num_marks > MAX_MARKS) ? MAX_MARKS : int'(cfg_num_marks);
   endfunction

   function automatic longint unsigned reach_limit();
      return eff_bin() * (2 * longint'(cfg_half_bins) + 1);
   endfunction

   function automatic void bump_count(int m1, int m2, longint unsigned bin);
      int idx;
      idx = (m1 * MAX_MARKS + m2) * NUM_BINS + int'(bin);
      if (hist_count[idx] != 32'hFFFF_FFFF) hist_count[idx]++;
   endfunction

   // Compute the result of one word and advance the predictor state
   function automatic result_type correlate(logic kind, logic [31:0] t, logic [3:0] mark,
                                            logic [3:0] r1, logic [3:0] r2, logic [5:0] rb);
      result_type r;
      longint unsigned bs, h, lim, d, a, b1;
      int nm, pos, pairs, k, m2;
      r = '{STAT_OK, 8'd0, 32'd0};
      bs = eff_bin();
      h = cfg_half_bins;
      nm = eff_marks();
      lim = reach_limit();
      pairs = 0;
      if (kind) begin
         if (r1 == 0 || r1 > nm || r2 == 0 || r2 > nm) r.status = STAT_BAD_MARK;
         else if (rb <= 2 * h)
            r.count = hist_count[((r1 - 1) * MAX_MARKS + (r2 - 1)) * NUM_BINS + rb];
      end else if (mark == 0 || mark > nm) begin
         r.status = STAT_BAD_MARK;
      end else if (t < last_spike_time) begin
         r.status = STAT_ORDER;
      end else begin
         if (win_fill >= WIN_DEPTH) begin
            d = t - win_time[win_head];
            if (2 * d <= lim) r.status = STAT_OVERFLOW;
            win_fill = WIN_DEPTH - 1;
         end
         for (k = 0; k < win_fill; k++) begin
            pos = (win_head + WIN_DEPTH - 1 - k) % WIN_DEPTH;
            d = t - win_time[pos];
            a = 2 * d;
            if (a > lim) break;
            m2 = win_mark[pos];
            b1 = (a <= bs) ? h : h - ((a - bs + 2 * bs - 1) / (2 * bs));
            bump_count(mark - 1, m2, b1);
            pairs++;
            if (a < lim) begin
               bump_count(m2, mark - 1, h + (a + bs) / (2 * bs));
               pairs++;
            end
         end
         win_time[win_head] = t;
         win_mark[win_head] = 3'(mark - 1);
         win_head = (win_head + 1) % WIN_DEPTH;
         win_fill++;
         last_spike_time = t;
         r.pairs = (pairs > 255) ? 8'd255 : 8'(pairs);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
   endtask

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      result_type want;
      if (!reset && req_valid && req_ready) begin
         want = correlate(req_kind, req_spike_time, req_spike_mark, req_read_first_mark,
                          req_read_second_mark, req_read_bin);
         if (cur_fixed) want = cur_want;
         pending_results.push_back(want);
         if (req_kind) reads_seen++;
         else spikes_seen++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_status), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status == STAT_OVERFLOW) overflow_seen++;
            if (rsp_status != want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_pairs_added != want.pairs)
               report_mismatch("pairs_added", rsp_pairs_added, want.pairs);
            if (rsp_count_value != want.count)
               report_mismatch("count_value", rsp_count_value, want.count);
         end
      end
   end

   // Watchdog: count cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > WATCH_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 0;
         end
         rsp_ready <= !(idling_on && $urandom_range(99) < 19);
      end
   end

   // Write one register through the setup and access phases
   task automatic csr_write(csr_reg_type idx, logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         REG_BIN_SIZE:  cfg_bin_size = value[15:0];
         REG_HALF_BINS: cfg_half_bins = value[4:0];
         default:       cfg_num_marks = value[3:0];
      endcase
      @(negedge clock);
   endtask

   // Hold the sender until every expected word has come back
   task automatic drain();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Offer one word; called and returns at a falling edge
   task automatic send_word(stim_row_type row);
      while (idling_on && $urandom_range(99) < 19) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= row.kind;
      req_spike_time <= row.t;
      req_spike_mark <= row.mark;
      req_read_first_mark <= row.r1;
      req_read_second_mark <= row.r2;
      req_read_bin <= row.rb;
      cur_fixed = row.fixed;
      cur_want = row.want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic stim_row_type random_row();
      stim_row_type row;
      longint unsigned lim, delta, nt;
      int nm, pick;
      row = '{default: '0};
      nm = eff_marks();
      lim = reach_limit();
      pick = $urandom_range(99);
      row.kind = ($urandom_range(99) < 30);
      if (row.kind) begin
         if ($urandom_range(99) < 85 && nm > 0) begin
            row.r1 = 4'($urandom_range(nm, 1));
            row.r2 = 4'($urandom_range(nm, 1));
            row.rb = 6'($urandom_range(2 * cfg_half_bins, 0));
         end else begin
            row.r1 = 4'($urandom_range(15));
            row.r2 = 4'($urandom_range(15));
            row.rb = 6'($urandom_range(63));
         end
      end else begin
         if (pick < 70) delta = $urandom_range(lim / 6 + 1, 0);
         else if (pick < 84) delta = 0;
         else if (pick < 95) delta = $urandom_range(2 * lim, 0);
         else delta = $urandom;
         if (pick >= 96 && cur_time > 100) begin
            row.t = cur_time - 32'($urandom_range(100, 1));   // step back in time
         end else begin
            nt = longint'(cur_time) + delta;
            cur_time = (nt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(nt);
            row.t = cur_time;
         end
         if ($urandom_range(99) < 88 && nm > 0) row.mark = 4'($urandom_range(nm, 1));
         else row.mark = 4'($urandom_range(15));
         // keep the generator's notion of time tied to what was accepted
         if (row.mark == 0 || row.mark > nm) cur_time = last_spike_time;
      end
      return row;
   endfunction

   // Directed rows: after-reset reads, bad marks and bins, order error, first pairs
   stim_row_type directed [] = '{
      '{1, 0, 0, 1, 1, 0, 1, '{STAT_OK, 0, 0}},
      '{1, 0, 0, 0, 1, 0, 1, '{STAT_BAD_MARK, 0, 0}},
      '{1, 0, 0, 8, 9, 0, 1, '{STAT_BAD_MARK, 0, 0}},
      '{1, 0, 0, 15, 15, 63, 1, '{STAT_BAD_MARK, 0, 0}},
      '{1, 0, 0, 8, 8, 63, 1, '{STAT_OK, 0, 0}},
      '{1, 0, 0, 1, 1, 21, 1, '{STAT_OK, 0, 0}},
      '{0, 100, 0, 0, 0, 0, 1, '{STAT_BAD_MARK, 0, 0}},
      '{0, 100, 15, 0, 0, 0, 1, '{STAT_BAD_MARK, 0, 0}},
      '{0, 100, 9, 0, 0, 0, 1, '{STAT_BAD_MARK, 0, 0}},
      '{0, 100, 1, 0, 0, 0, 1, '{STAT_OK, 0, 0}},
      '{0, 50, 1, 0, 0, 0, 1, '{STAT_ORDER, 0, 0}},
      '{0, 100, 2, 0, 0, 0, 1, '{STAT_OK, 2, 0}},
      '{1, 0, 0, 2, 1, 10, 1, '{STAT_OK, 0, 1}},
      '{1, 0, 0, 1, 2, 10, 1, '{STAT_OK, 0, 1}},
      '{0, 110, 3, 0, 0, 0, 1, '{STAT_OK, 4, 0}},
      '{0, 111, 1, 0, 0, 0, 1, '{STAT_OK, 2, 0}},
      '{0, 121, 8, 0, 0, 0, 0, '{STAT_OK, 0, 0}},
      '{0, 131, 4, 0, 0, 0, 0, '{STAT_OK, 0, 0}},
      '{1, 0, 0, 3, 1, 0, 0, '{STAT_OK, 0, 0}},
      '{1, 0, 0, 1, 3, 20, 0, '{STAT_OK, 0, 0}},
      '{1, 0, 0, 8, 4, 5, 0, '{STAT_OK, 0, 0}},
      '{1, 0, 0, 4, 8, 15, 0, '{STAT_OK, 0, 0}}
   };

   // Register settings per random phase: bin_size, half_bins, num_marks
   int phase_bs [8] = '{1, 0, 65535, 3, 7, 2, 100, 5};
   int phase_hb [8] = '{10, 0, 31, 5, 31, 2, 7, 3};
   int phase_nm [8] = '{8, 1, 8, 4, 15, 0, 8, 8};

   initial begin
      stim_row_type row;
      int p, n;
      cfg_bin_size = 1;
      cfg_half_bins = 10;
      cfg_num_marks = 8;
      win_head = 0;
      win_fill = 0;
      last_spike_time = 0;
      cur_time = 0;
      foreach (hist_count[i]) hist_count[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed[i]) send_word(directed[i]);
      req_valid <= 0;
      drain();
      cur_time = last_spike_time;

      for (p = 0; p < 8; p++) begin
         csr_write(REG_BIN_SIZE, 32'(phase_bs[p]) | ($urandom & 32'hFFFF_0000));
         csr_write(REG_HALF_BINS, 32'(phase_hb[p]));
         csr_write(REG_NUM_MARKS, 32'(phase_nm[p]));
         idling_on = (p != 3);   // one phase runs at full rate on both sides
         if (p == 7) cur_time = 32'hFFFF_FF00;   // push times to the top of the range
         for (n = 0; n < 250; n++) begin
            if (p == 2 && n == 40) hold_req = 1;   // long receiver hold-off, input fills
            if (p == 1 && n == 120) begin
               req_valid <= 0;
               drain();
            end
            row = random_row();
            send_word(row);
         end
         req_valid <= 0;
         drain();
         cur_time = last_spike_time;
      end

      cur_fixed = 0;
      drain();
      repeat (50) @(negedge clock);
      $display("covered %0d spikes, %0d count reads, %0d overflow words, %0d results",
               spikes_seen, reads_seen, overflow_seen, results_seen);
      $display("directed rows at reset values, then 8 random phases; %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

>>> files.f
sv/scc_pkg.sv
sv/scc_ram.sv
sv/spike_cross_correlogram_unit.sv
tb/spike_cross_correlogram_unit_tb.sv
